// File: design/lvlp_pkg.sv
// Shared constants and types of the label/value line parser.
`default_nettype none

package lvlp_pkg;

  // Width of the value magnitude accumulator (valid range 16 to 63).
  localparam int unsigned MagW = 31;
  // Working width for the cap against the largest 32-bit mantissa.
  localparam int unsigned CapW = (MagW > 32) ? MagW : 32;
  // Width of magnitude * 10 + digit before saturation.
  localparam int unsigned ProdW = MagW + 4;

  localparam logic [31:0] MANT_CAP = 32'h7FFF_FFFF;
  localparam logic [3:0]  FRAC_MAX = 4'd15;
  localparam logic [2:0]  LEN_LONG = 3'd4;
  localparam logic [2:0]  LEN_FULL = 3'd3;

  // Control characters and value characters.
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  // Label letters.
  localparam logic [7:0] CH_V = 8'h56;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_R = 8'h52;

  // Field codes.
  localparam logic [2:0] FIELD_V   = 3'd0;
  localparam logic [2:0] FIELD_VPV = 3'd1;
  localparam logic [2:0] FIELD_PPV = 3'd2;
  localparam logic [2:0] FIELD_CS  = 3'd3;
  localparam logic [2:0] FIELD_ERR = 3'd4;

  // One result word.
  typedef struct packed {
    logic [2:0]         field_code;
    logic signed [31:0] mantissa;
    logic [3:0]         fraction_digits;
    logic               bad_line;
  } result_t;

endpackage

`default_nettype wire

// File: design/label_value_line_parser.sv
// Top level of the label/value line parser: byte-wide state update and result buffer.
//
// Usage: the input channel (in_valid, in_ready, in_rx_byte) takes one received
// ASCII byte per word. Lines have the form label TAB value NEWLINE. For the
// labels V, VPV, PPV, CS and ERR, the newline that closes the value produces one
// result word on the output channel (out_valid, out_ready and the four out_
// fields): field code, signed mantissa with the point removed, number of
// fraction digits and a bad-line flag. All other bytes produce no result.
// A result is registered in the output register, or in the skid register while one is held.
// Throughput: one byte per cycle while in_ready is high. The parser state is updated
// in a single registered pass per byte, so bytes may follow each other in every cycle.
// Stall: the output register is backed by a one-word skid register, so a byte is
// still taken while a result waits; only when both are full does in_ready fall.
// Reset: synchronous, active low. The label, value state and the valid flags of both
// result registers are cleared, and nothing is presented on the output.
`default_nettype none

module label_value_line_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [7:0]         in_rx_byte,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [2:0]         out_field_code,
  output      logic signed [31:0] out_mantissa,
  output      logic [3:0]         out_fraction_digits,
  output      logic               out_bad_line
);
  import lvlp_pkg::*;

  // Parser state.
  logic [7:0]      label_r [3];
  logic [7:0]      label_nxt [3];
  logic [2:0]      len_r, len_nxt;
  logic            reading_r, reading_nxt;
  logic            neg_r, neg_nxt;
  logic            point_r, point_nxt;
  logic [3:0]      frac_r, frac_nxt;
  logic [MagW-1:0] mag_r, mag_nxt;
  logic            err_r, err_nxt;

  // Result buffer: output register plus skid register.
  result_t         out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;
  result_t         skid_r, skid_nxt;
  logic            skid_valid_r, skid_valid_nxt;

  logic            accept;
  logic            emit;
  result_t         res;
  logic            code_ok;
  logic [2:0]      code;
  logic [7:0]      c;
  logic            is_digit;
  logic            is_letter;
  logic [3:0]      digit;
  logic [ProdW-1:0] prod;
  logic [CapW-1:0] mag_ext;
  logic [31:0]     mag_capped;

  assign c        = in_rx_byte;
  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;

  assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_letter = ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
  assign digit     = 4'(c - CH_ZERO);

  // Label decode: the stored length decides which characters take part.
  always_comb begin
    code_ok = 1'b0;
    code    = FIELD_V;
    if (len_r == 3'd1 && label_r[0] == CH_V) begin
      code_ok = 1'b1;
      code    = FIELD_V;
    end else if (len_r == 3'd2 && label_r[0] == CH_C && label_r[1] == CH_S) begin
      code_ok = 1'b1;
      code    = FIELD_CS;
    end else if (len_r == LEN_FULL) begin
      if (label_r[0] == CH_V && label_r[1] == CH_P && label_r[2] == CH_V) begin
        code_ok = 1'b1;
        code    = FIELD_VPV;
      end else if (label_r[0] == CH_P && label_r[1] == CH_P && label_r[2] == CH_V) begin
        code_ok = 1'b1;
        code    = FIELD_PPV;
      end else if (label_r[0] == CH_E && label_r[1] == CH_R && label_r[2] == CH_R) begin
        code_ok = 1'b1;
        code    = FIELD_ERR;
      end
    end
  end

  // Decimal accumulate: magnitude * 10 + digit from two shifts and an add.
  // Anything beyond the accumulator's range saturates at all ones.
  assign prod = (ProdW'(mag_r) << 3) + (ProdW'(mag_r) << 1) + ProdW'(digit);

  // The emitted magnitude is also capped at the largest positive 32-bit value.
  assign mag_ext    = CapW'(mag_r);
  assign mag_capped = (mag_ext > CapW'(MANT_CAP)) ? MANT_CAP : mag_ext[31:0];

  always_comb begin
    res.field_code      = code;
    res.mantissa        = neg_r ? $signed(32'd0 - mag_capped) : $signed(mag_capped);
    res.fraction_digits = frac_r;
    res.bad_line        = err_r;
  end

  // Per-byte state update. Order of the checks decides the meaning of a byte.
  always_comb begin
    label_nxt   = label_r;
    len_nxt     = len_r;
    reading_nxt = reading_r;
    neg_nxt     = neg_r;
    point_nxt   = point_r;
    frac_nxt    = frac_r;
    mag_nxt     = mag_r;
    err_nxt     = err_r;
    emit        = 1'b0;
    if (accept) begin
      priority if (c == CH_CR) begin
        // Carriage returns are ignored entirely.
      end else if (c == CH_NL && len_r != 3'd0 && reading_r) begin
        // A newline closing a value: report parsed labels and start a fresh line.
        // The magnitude, point and fraction count are left for the next tab to clear.
        emit         = code_ok;
        err_nxt      = 1'b0;
        len_nxt      = 3'd0;
        label_nxt[0] = '0;
        label_nxt[1] = '0;
        label_nxt[2] = '0;
        reading_nxt  = 1'b0;
        neg_nxt      = 1'b0;
      end else if (c == CH_TAB) begin
        mag_nxt     = '0;
        point_nxt   = 1'b0;
        frac_nxt    = '0;
        reading_nxt = 1'b1;
        neg_nxt     = 1'b0;
      end else if (reading_r) begin
        // Value characters count only under a parsed label.
        if (code_ok) begin
          priority if (c == CH_MINUS) begin
            neg_nxt = 1'b1;
          end else if ((c == CH_DOT || c == CH_COMMA) && !point_r) begin
            point_nxt = 1'b1;
          end else if (is_digit) begin
            if (point_r && frac_r != FRAC_MAX) begin
              frac_nxt = frac_r + 4'd1;
            end
            if (prod > ProdW'({MagW{1'b1}})) begin
              mag_nxt = {MagW{1'b1}};
            end else begin
              mag_nxt = prod[MagW-1:0];
            end
          end else begin
            err_nxt = 1'b1;
          end
        end
      end else if (is_letter) begin
        // Letters build the label; a fourth one marks it as too long.
        if (len_r < LEN_FULL) begin
          label_nxt[len_r[1:0]] = c;
          len_nxt               = len_r + 3'd1;
        end else begin
          len_nxt = LEN_LONG;
        end
      end
    end
  end

  // Result buffer: a new result goes to the output register when that is free
  // or draining, otherwise into the skid register. The skid register empties
  // into the output register first, and blocks input while it is full.
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = emit;
      end
    end else if (emit) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_r[0]   <= '0;
      label_r[1]   <= '0;
      label_r[2]   <= '0;
      len_r        <= '0;
      reading_r    <= 1'b0;
      neg_r        <= 1'b0;
      point_r      <= 1'b0;
      frac_r       <= '0;
      mag_r        <= '0;
      err_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      label_r      <= label_nxt;
      len_r        <= len_nxt;
      reading_r    <= reading_nxt;
      neg_r        <= neg_nxt;
      point_r      <= point_nxt;
      frac_r       <= frac_nxt;
      mag_r        <= mag_nxt;
      err_r        <= err_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_field_code      = out_r.field_code;
  assign out_mantissa        = out_r.mantissa;
  assign out_fraction_digits = out_r.fraction_digits;
  assign out_bad_line        = out_r.bad_line;

`ifndef SYNTH
  // The skid register only fills behind a held output word.
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  // Fraction digits are only counted once a point has been seen.
  a_frac_needs_point : assert property (@(posedge clk) disable iff (!rst_n)
    (frac_r != 4'd0) |-> point_r)
    else $error("fraction count without a decimal point");

  // A shown result always carries a known field code.
  a_code_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_field_code <= FIELD_ERR))
    else $error("field code out of range");

  // A result follows only from a newline taken in the previous cycle or a waiting word.
  a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !skid_valid_r && !(accept && c == CH_NL)) |=> !out_valid_r)
    else $error("result appeared without a closing newline");
`endif

endmodule

`default_nettype wire
